@@ hdl/ffpra_pkg.sv @@
// ---------------------------------------------------------------------------
// ffpra_pkg
// Shared types, codes and helpers of the first-fit page range allocator.
// ---------------------------------------------------------------------------
package ffpra_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int PAGE_SIZE      = 4096;

    localparam int ADDR_W  = 32;
    localparam int PAGES_W = 21;
    localparam int FLAGS_W = 8;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL   = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PAGES_W-1:0] pages;
        logic               used;
        logic [FLAGS_W-1:0] flags;
    } entry_t;

    typedef struct packed {
        logic   pop;
        logic   push;
        entry_t push_entry;
    } chain_ctl_t;

    function automatic logic [ADDR_W-1:0] page_bytes(input logic [PAGES_W-1:0] pages);
        logic [63:0] p;
        p = 64'(pages) * 64'(PAGE_SIZE);
        return p[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] align_down(input logic [ADDR_W-1:0] a);
        logic [63:0] r;
        r = 64'(a) % 64'(PAGE_SIZE);
        return a - r[ADDR_W-1:0];
    endfunction

    function automatic logic [PAGES_W-1:0] span_pages(input logic [ADDR_W-1:0] start_addr,
                                                      input logic [ADDR_W-1:0] end_addr);
        logic [ADDR_W-1:0] d;
        logic [63:0]       q;
        d = end_addr - start_addr;
        q = 64'(d) / 64'(PAGE_SIZE);
        return (q > 64'(PAGES_MAX)) ? PAGES_MAX : q[PAGES_W-1:0];
    endfunction

    function automatic logic [PAGES_W-1:0] sat_add(input logic [PAGES_W-1:0] a,
                                                   input logic [PAGES_W-1:0] b);
        logic [PAGES_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PAGES_W] ? PAGES_MAX : s[PAGES_W-1:0];
    endfunction

endpackage

@@ hdl/first_fit_page_range_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_page_range_allocator
// First-fit page range allocator with coalescing of touching free ranges.
//
// Requests enter on in_valid / in_stall, results leave on out_valid /
// out_stall; a request is taken when valid is high and stall is low.
// The range table is a chain of MAX_RANGES cells ordered by base address;
// entries are popped at the head and pushed at the tail during table passes.
// A request first circulates the whole table once to search it, then, if it
// changes the table, streams it again through the insert and coalesce stage.
// An add to a full table and an unknown action skip the table passes.
// One request is worked on at a time; in_stall is high while busy.
// A finished result waits in the output register while out_stall is high,
// and the next request may be taken meanwhile.
// Reset empties the table at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module first_fit_page_range_allocator
    import ffpra_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ACT_W-1:0]   action,
    input  logic [ADDR_W-1:0]  region_start,
    input  logic [ADDR_W-1:0]  region_end,
    input  logic [PAGES_W-1:0] requested_pages,
    input  logic [FLAGS_W-1:0] range_flags,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [ADDR_W-1:0]  address,
    output logic [PAGES_W-1:0] freed_pages
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_RANGES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      found_reg, found_next;
    logic               found_v_reg, found_v_next;
    entry_t             found_e_reg, found_e_next;
    logic               inserted_reg, inserted_next;
    logic               ins_en_reg, ins_en_next;
    logic               mod_en_reg, mod_en_next;
    logic               merge_reg, merge_next;
    logic               acc_v_reg, acc_v_next;
    entry_t             acc_reg, acc_next;
    entry_t             ins_reg, ins_next;
    logic [ACT_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0]  start_reg, start_next;
    logic [PAGES_W-1:0] req_reg, req_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic [STAT_W-1:0]  rstat_reg, rstat_next;
    logic [ADDR_W-1:0]  raddr_reg, raddr_next;
    logic [PAGES_W-1:0] rfreed_reg, rfreed_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0]  address_reg, address_next;
    logic [PAGES_W-1:0] freed_reg, freed_next;

    chain_ctl_t            ctl;
    entry_t                cell_entry [MAX_RANGES];
    logic [MAX_RANGES-1:0] cell_valid;
    logic [MAX_RANGES-1:0] cell_filled;
    entry_t                head;
    entry_t                s;
    logic                  s_v;
    logic                  split;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            entry_t r_entry;
            logic   r_valid;
            logic   l_filled;
            if (gi == MAX_RANGES - 1)
            begin : g_last
                assign r_entry = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid
                assign r_entry = cell_entry[gi+1];
                assign r_valid = cell_valid[gi+1];
            end
            if (gi == 0)
            begin : g_first
                assign l_filled = 1'b1;
            end
            else
            begin : g_rest
                assign l_filled = cell_filled[gi-1];
            end
            ffpra_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .right_entry (r_entry),
                .right_valid (r_valid),
                .left_filled (l_filled),
                .entry       (cell_entry[gi]),
                .valid       (cell_valid[gi]),
                .filled      (cell_filled[gi])
            );
        end
    endgenerate

    assign head  = cell_entry[0];
    assign split = found_e_reg.pages > req_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        found_v_next   = found_v_reg;
        found_e_next   = found_e_reg;
        inserted_next  = inserted_reg;
        ins_en_next    = ins_en_reg;
        mod_en_next    = mod_en_reg;
        merge_next     = merge_reg;
        acc_v_next     = acc_v_reg;
        acc_next       = acc_reg;
        ins_next       = ins_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        req_next       = req_reg;
        flags_next     = flags_reg;
        rstat_next     = rstat_reg;
        raddr_next     = raddr_reg;
        rfreed_next    = rfreed_reg;
        status_next    = status_reg;
        address_next   = address_reg;
        freed_next     = freed_reg;
        ctl            = '0;
        s              = head;
        s_v            = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = action;
                    start_next    = region_start;
                    ins_next      = '{addr: align_down(region_start),
                                      pages: span_pages(region_start, region_end),
                                      used: 1'b0, flags: '0};
                    req_next      = (requested_pages == '0) ? PAGES_W'(1) : requested_pages;
                    flags_next    = range_flags;
                    k_next        = '0;
                    n_next        = count_reg;
                    pos_next      = '0;
                    found_v_next  = 1'b0;
                    rstat_next    = ST_NOT_FOUND;
                    raddr_next    = '0;
                    rfreed_next   = '0;
                    state_next    = S_SCAN;
                    case (action)
                        ACT_ADD:
                        begin
                            if (count_reg >= FULL)
                            begin
                                rstat_next = ST_TABLE_FULL;
                                state_next = S_RESP;
                            end
                        end
                        ACT_ALLOC, ACT_FREE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (k_reg < n_reg)
                begin
                    ctl.pop        = 1'b1;
                    ctl.push       = 1'b1;
                    ctl.push_entry = head;
                    k_next         = k_reg + CW'(1);
                    case (op_reg)
                        ACT_ADD:
                        begin
                            if (head.addr < ins_reg.addr)
                            begin
                                pos_next = k_reg + CW'(1);
                            end
                        end
                        ACT_ALLOC:
                        begin
                            if (!found_v_reg && !head.used && head.pages >= req_reg)
                            begin
                                found_v_next = 1'b1;
                                found_next   = k_reg;
                                found_e_next = head;
                            end
                        end
                        default:
                        begin
                            if (!found_v_reg && head.addr == start_reg)
                            begin
                                found_v_next = 1'b1;
                                found_next   = k_reg;
                                found_e_next = head;
                            end
                        end
                    endcase
                end
                else
                begin
                    k_next        = '0;
                    inserted_next = 1'b0;
                    acc_v_next    = 1'b0;
                    state_next    = S_RESP;
                    case (op_reg)
                        ACT_ADD:
                        begin
                            rstat_next  = ST_OK;
                            ins_en_next = 1'b1;
                            mod_en_next = 1'b0;
                            merge_next  = 1'b1;
                            state_next  = S_APPLY;
                        end
                        ACT_ALLOC:
                        begin
                            if (!found_v_reg)
                            begin
                                rstat_next = ST_NO_FREE;
                            end
                            else if (split && n_reg >= FULL)
                            begin
                                rstat_next = ST_TABLE_FULL;
                            end
                            else
                            begin
                                rstat_next  = ST_OK;
                                raddr_next  = found_e_reg.addr;
                                ins_en_next = split;
                                mod_en_next = 1'b1;
                                merge_next  = 1'b0;
                                pos_next    = found_reg + CW'(1);
                                ins_next    = '{addr: found_e_reg.addr + page_bytes(req_reg),
                                                pages: found_e_reg.pages - req_reg,
                                                used: 1'b0, flags: '0};
                                state_next  = S_APPLY;
                            end
                        end
                        default:
                        begin
                            if (!found_v_reg)
                            begin
                                rstat_next = ST_NOT_FOUND;
                            end
                            else if (!found_e_reg.used)
                            begin
                                rstat_next = ST_ALREADY_FREE;
                            end
                            else
                            begin
                                rstat_next  = ST_OK;
                                rfreed_next = found_e_reg.pages;
                                ins_en_next = 1'b0;
                                mod_en_next = 1'b1;
                                merge_next  = 1'b1;
                                state_next  = S_APPLY;
                            end
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                if (ins_en_reg && !inserted_reg && k_reg == pos_reg)
                begin
                    s             = ins_reg;
                    s_v           = 1'b1;
                    inserted_next = 1'b1;
                end
                else if (k_reg < n_reg)
                begin
                    ctl.pop = 1'b1;
                    s       = head;
                    s_v     = 1'b1;
                    k_next  = k_reg + CW'(1);
                    if (mod_en_reg && k_reg == found_reg)
                    begin
                        if (op_reg == ACT_ALLOC)
                        begin
                            s.used  = 1'b1;
                            s.flags = flags_reg;
                            if (ins_en_reg)
                            begin
                                s.pages = req_reg;
                            end
                        end
                        else
                        begin
                            s.used = 1'b0;
                        end
                    end
                end
                if (s_v)
                begin
                    if (acc_v_reg && merge_reg && !acc_reg.used && !s.used &&
                        (acc_reg.addr + page_bytes(acc_reg.pages)) == s.addr)
                    begin
                        acc_next.pages = sat_add(acc_reg.pages, s.pages);
                    end
                    else
                    begin
                        ctl.push       = acc_v_reg;
                        ctl.push_entry = acc_reg;
                        acc_next       = s;
                        acc_v_next     = 1'b1;
                    end
                end
                else
                begin
                    ctl.push       = acc_v_reg;
                    ctl.push_entry = acc_reg;
                    acc_v_next     = 1'b0;
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rstat_reg;
                    address_next   = raddr_reg;
                    freed_next     = rfreed_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        n_reg        <= n_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        found_v_reg  <= found_v_next;
        found_e_reg  <= found_e_next;
        inserted_reg <= inserted_next;
        ins_en_reg   <= ins_en_next;
        mod_en_reg   <= mod_en_next;
        merge_reg    <= merge_next;
        acc_v_reg    <= acc_v_next;
        acc_reg      <= acc_next;
        ins_reg      <= ins_next;
        op_reg       <= op_next;
        start_reg    <= start_next;
        req_reg      <= req_next;
        flags_reg    <= flags_next;
        rstat_reg    <= rstat_next;
        raddr_reg    <= raddr_next;
        rfreed_reg   <= rfreed_next;
        status_reg   <= status_next;
        address_reg  <= address_next;
        freed_reg    <= freed_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign address     = address_reg;
    assign freed_pages = freed_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("range count beyond table size");

    a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with range count");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push && !ctl.pop |-> count_reg < FULL)
        else $error("push into a full chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("request taken but block stayed idle");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !ctl.pop && !ctl.push)
        else $error("chain moved outside a table pass");

endmodule

@@ hdl/ffpra_cell.sv @@
// ---------------------------------------------------------------------------
// ffpra_cell
// One table slot of the range chain: shifts toward the head on pop and
// captures the pushed entry when it is the first empty slot.
// ---------------------------------------------------------------------------
module ffpra_cell
    import ffpra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chain_ctl_t ctl,
    input  entry_t     right_entry,
    input  logic       right_valid,
    input  logic       left_filled,
    output entry_t     entry,
    output logic       valid,
    output logic       filled
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   take;

    always_comb
    begin
        filled     = ctl.pop ? right_valid : valid_reg;
        take       = ctl.push && !filled && left_filled;
        entry_next = entry_reg;
        if (take)
        begin
            entry_next = ctl.push_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
        valid_next = filled | take;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule
